>>> design/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared types and constants of the rtd trimmed-mean temperature block.
// ----------------------------------------------------------------------------
`default_nettype none
package rtd_pkg;

  localparam int DEF_SAMPLES = 10;
  localparam int CODE_W      = 16;
  localparam int RES_W       = 18;
  localparam int TEMP_W      = 18;
  localparam int R0_W        = 21;
  localparam int A_W         = 24;
  localparam int B_W         = 22;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int DIV_N_W     = 64;
  localparam int DIV_D_W     = 22;

  localparam logic [CFG_IDX_W-1:0] REG_R0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B  = 2'd2;

  localparam logic [R0_W-1:0]         DEF_R0   = 21'd100000;
  localparam logic [A_W-1:0]          DEF_A    = 24'd3908300;
  localparam logic signed [B_W-1:0]   DEF_B    = -22'sd577500;
  localparam logic signed [TEMP_W-1:0] T_MIN   = -18'sd30000;
  localparam logic signed [TEMP_W-1:0] T_MAX   = 18'sd90000;

  typedef struct packed {
    logic [R0_W-1:0]       r0;
    logic [A_W-1:0]        a;
    logic signed [B_W-1:0] b;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

>>> design/rtd_front.sv
// ----------------------------------------------------------------------------
// rtd_front
// Group accumulator (sum, max, min) and a two-entry queue of trimmed means.
// ----------------------------------------------------------------------------
`default_nettype none
module rtd_front #(
  parameter int SAMPLES = rtd_pkg::DEF_SAMPLES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [rtd_pkg::CODE_W-1:0] code,
  output logic                            full,
  output logic                            mq_valid,
  output logic [rtd_pkg::CODE_W-1:0]      mq_mean,
  input  wire logic                       mq_pop
);
  import rtd_pkg::*;

  localparam int SUM_W = $clog2(SAMPLES * 65535 + 1);
  localparam int CNT_W = $clog2(SAMPLES + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CODE_W-1:0] max_r, max_nxt, min_r, min_nxt;
  logic [SUM_W-1:0]  trimmed;
  logic [CODE_W-1:0] mean;
  logic              accept, last;

  logic [CODE_W-1:0] qmem_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        qcnt_r;

  assign accept  = push && !full;
  assign max_nxt = (code > max_r) ? code : max_r;
  assign min_nxt = (code < min_r) ? code : min_r;
  assign sum_nxt = sum_r + SUM_W'(code);
  assign cnt_nxt = cnt_r + CNT_W'(1);
  assign last    = (cnt_nxt == CNT_W'(SAMPLES));
  assign trimmed = sum_nxt - SUM_W'(max_nxt) - SUM_W'(min_nxt);
  // divide by eight, saturating
  assign mean    = ((trimmed >> 3) > SUM_W'(65535)) ? 16'hFFFF : CODE_W'(trimmed >> 3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      max_r <= '0;
      min_r <= '1;
    end else if (accept) begin
      if (last) begin
        cnt_r <= '0;
        sum_r <= '0;
        max_r <= '0;
        min_r <= '1;
      end else begin
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
        max_r <= max_nxt;
        min_r <= min_nxt;
      end
    end
  end

  assign full     = (qcnt_r == 2'd2);
  assign mq_valid = (qcnt_r != 2'd0);
  assign mq_mean  = qmem_r[rp_r];

  always_ff @(posedge clk) begin
    if (accept && last) begin
      qmem_r[wp_r] <= mean;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      qcnt_r <= 2'd0;
    end else begin
      if (accept && last) begin
        wp_r <= !wp_r;
      end
      if (mq_pop && mq_valid) begin
        rp_r <= !rp_r;
      end
      qcnt_r <= qcnt_r + 2'(accept && last) - 2'(mq_pop && mq_valid);
    end
  end

endmodule
`default_nettype wire

>>> design/rtd_div.sv
// ----------------------------------------------------------------------------
// rtd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rtd_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rtd_pkg::div_req_t           req,
  output logic                             done,
  output logic [rtd_pkg::DIV_N_W-1:0]      quot
);
  import rtd_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] num_r, quot_r;
  logic [DIV_D_W:0]   rem_r, rem_sh;
  logic [DIV_D_W-1:0] den_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;
  logic               ge;

  assign rem_sh = {rem_r[DIV_D_W-1:0], num_r[DIV_N_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r  <= req.dividend;
      den_r  <= req.divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      num_r  <= num_r << 1;
      rem_r  <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quot_r <= {quot_r[DIV_N_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

>>> design/rtd_back.sv
// ----------------------------------------------------------------------------
// rtd_back
// Conversion sequencer: resistance, root argument, square root, temperature.
// ----------------------------------------------------------------------------
`default_nettype none
module rtd_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rtd_pkg::cfg_t               cfg,
  input  wire logic                        mq_valid,
  input  wire logic [rtd_pkg::CODE_W-1:0]  mq_mean,
  output logic                             mq_pop,
  input  wire logic                        out_pop,
  output logic                             out_valid,
  output logic [rtd_pkg::CODE_W-1:0]       out_mean,
  output logic [rtd_pkg::RES_W-1:0]        out_res,
  output logic signed [rtd_pkg::TEMP_W-1:0] out_temp,
  output logic                             out_flag
);
  import rtd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVR  = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_PROD1 = 4'd3;
  localparam logic [3:0] S_PROD2 = 4'd4;
  localparam logic [3:0] S_PROD3 = 4'd5;
  localparam logic [3:0] S_QDIV  = 4'd6;
  localparam logic [3:0] S_DN    = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_NMUL  = 4'd9;
  localparam logic [3:0] S_TDIV  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]  st_r;
  logic        use_def, bneg;
  logic [R0_W-1:0] r0;
  logic [A_W-1:0]  a;
  logic signed [B_W-1:0] b;
  logic [B_W-1:0]  ub;

  div_req_t        dreq;
  logic            ddone;
  logic [DIV_N_W-1:0] dquot;

  logic [CODE_W-1:0] mean_r;
  logic [33:0]       y_r;
  logic [18:0]       rs;
  logic [16:0]       rt;
  logic [RES_W-1:0]  rq;
  logic [RES_W-1:0]  r_r;
  logic [R0_W-1:0]   ur_r;
  logic              dneg_r;
  logic [41:0]       m1_r;
  logic [63:0]       lo_r, qn_r;
  logic [47:0]       a2_r;
  logic [64:0]       dsum;
  logic [63:0]       v_r;
  logic [34:0]       rem_r, rem_sh, trial;
  logic [31:0]       root_r;
  logic [4:0]        scnt_r;
  logic signed [32:0] n;
  logic [31:0]       nmag;
  logic [47:0]       up_r;
  logic              nneg_r, flag_r;
  logic [DIV_N_W-1:0] mag;
  logic signed [21:0] tsig;
  logic signed [TEMP_W-1:0] t_r, tclamp;
  logic              out_free;

  assign use_def = (cfg.r0 == '0) || (cfg.a == '0);
  assign r0      = use_def ? DEF_R0 : cfg.r0;
  assign a       = use_def ? DEF_A : cfg.a;
  assign b       = (cfg.b == '0) ? DEF_B : cfg.b;
  assign bneg    = b[B_W-1];
  assign ub      = bneg ? B_W'(-b) : B_W'(b);

  rtd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (ddone),
    .quot (dquot)
  );

  always_comb begin
    dreq = '0;
    case (st_r)
      S_PROD3: begin
        dreq.start    = 1'b1;
        dreq.dividend = lo_r + {43'(m1_r[41:21]) * 43'd4000000, 21'b0};
        dreq.divisor  = DIV_D_W'(r0);
      end
      S_NMUL: begin
        dreq.start    = 1'b0;
      end
      default: begin
        dreq = '0;
      end
    endcase
    if (st_r == S_TDIV && !flag_r && scnt_r == 5'd0) begin
      dreq.start    = 1'b1;
      dreq.dividend = DIV_N_W'(up_r) + DIV_N_W'(ub >> 1);
      dreq.divisor  = ub;
    end
  end

  assign mq_pop = (st_r == S_IDLE) && mq_valid;

  // divide by 65535 by folding the upper half back onto the lower half
  assign rs = 19'(y_r[33:16]) + 19'(y_r[15:0]);
  assign rt = 17'(rs[18:16]) + 17'(rs[15:0]);
  assign rq = y_r[33:16] + RES_W'(rs[18:16]) + RES_W'(rt >= 17'd65535);

  assign dsum   = {17'b0, a2_r} + {1'b0, qn_r};
  assign rem_sh = {rem_r[32:0], v_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign n      = $signed({1'b0, root_r}) - $signed(33'(a));
  assign nmag   = n[32] ? 32'(-n) : 32'(n);
  assign mag    = (dquot > DIV_N_W'(1000000)) ? DIV_N_W'(1000000) : dquot;
  assign tsig   = (nneg_r != bneg) ? -$signed({1'b0, mag[20:0]}) : $signed({1'b0, mag[20:0]});
  assign tclamp = (tsig < 22'(T_MIN)) ? T_MIN :
                  (tsig > 22'(T_MAX)) ? T_MAX : TEMP_W'(tsig);
  assign out_free = !out_valid || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_valid <= 1'b0;
      scnt_r    <= '0;
    end else begin
      if (out_pop && st_r != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (mq_valid) begin
            mean_r <= mq_mean;
            y_r    <= 34'(mq_mean) * 34'd250000 + 34'd32767;
            st_r   <= S_DIVR;
          end
        end
        S_DIVR: begin
          r_r  <= rq;
          st_r <= S_DIFF;
        end
        S_DIFF: begin
          dneg_r <= (R0_W'(r_r) > r0);
          ur_r   <= (R0_W'(r_r) > r0) ? R0_W'(r_r) - r0 : r0 - R0_W'(r_r);
          st_r   <= S_PROD1;
        end
        S_PROD1: begin
          m1_r <= 42'(ub) * 42'(ur_r);
          a2_r <= 48'(a) * 48'(a);
          st_r <= S_PROD2;
        end
        S_PROD2: begin
          lo_r <= 64'(m1_r[20:0] * 43'd4000000);
          st_r <= S_PROD3;
        end
        S_PROD3: begin
          st_r <= S_QDIV;
        end
        S_QDIV: begin
          if (ddone) begin
            qn_r <= dquot;
            st_r <= S_DN;
          end
        end
        S_DN: begin
          flag_r <= 1'b0;
          if ((bneg != dneg_r) || ur_r == '0) begin
            v_r  <= dsum[64] ? '1 : dsum[63:0];
          end else if (qn_r > {16'b0, a2_r}) begin
            flag_r <= 1'b1;
          end else begin
            v_r <= {16'b0, a2_r} - qn_r;
          end
          rem_r  <= '0;
          root_r <= '0;
          scnt_r <= 5'd31;
          if ((bneg == dneg_r) && ur_r != '0 && qn_r > {16'b0, a2_r}) begin
            t_r  <= bneg ? T_MAX : T_MIN;
            st_r <= S_OUT;
          end else begin
            st_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          v_r <= v_r << 2;
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[30:0], 1'b0};
          end
          scnt_r <= scnt_r - 5'd1;
          if (scnt_r == 5'd0) begin
            st_r <= S_NMUL;
          end
        end
        S_NMUL: begin
          nneg_r <= n[32];
          up_r   <= 48'(nmag) * 48'd50000;
          scnt_r <= 5'd0;
          st_r   <= S_TDIV;
        end
        S_TDIV: begin
          scnt_r <= 5'd1;
          if (ddone) begin
            t_r  <= tclamp;
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_mean  <= mean_r;
            out_res   <= r_r;
            out_temp  <= t_r;
            out_flag  <= flag_r;
            st_r      <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/rtd_trimmed_mean_temperature.sv
// ----------------------------------------------------------------------------
// rtd_trimmed_mean_temperature
// Trimmed mean of ADC code groups and inverse Callendar-Van Dusen conversion.
// ----------------------------------------------------------------------------
// Codes are taken one per cycle while in_full is low. Each group of SAMPLES
// codes gives one result: the mean of the group less its largest and
// smallest code (sum divided by eight), the resistance in milliohms and the
// temperature in hundredths of a degree, with out_of_range set when the root
// argument is negative. The conversion time of each group is set
// by the shared one-bit-per-cycle divider (two divisions) and the
// 32-step square root; a two-entry queue of means lets codes keep arriving
// while a group converts. Registers may be written only while the block is
// idle; a zero R0 or A selects the built-in R0 and A, a zero B the built-in B.
`default_nettype none
module rtd_trimmed_mean_temperature #(
  parameter int SAMPLES_PER_READING = rtd_pkg::DEF_SAMPLES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [rtd_pkg::CODE_W-1:0]      in_adc_code,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [rtd_pkg::CODE_W-1:0]           out_mean_code,
  output logic [rtd_pkg::RES_W-1:0]            out_resistance_milliohm,
  output logic signed [rtd_pkg::TEMP_W-1:0]    out_temperature_centi_c,
  output logic                                 out_out_of_range,
  input  wire logic                            cfg_we,
  input  wire logic [rtd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rtd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rtd_pkg::*;

  cfg_t              cfg_r;
  logic              mq_valid, mq_pop, out_valid;
  logic [CODE_W-1:0] mq_mean;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.r0 <= DEF_R0;
      cfg_r.a  <= DEF_A;
      cfg_r.b  <= DEF_B;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_R0:  cfg_r.r0 <= cfg_wdata[R0_W-1:0];
        REG_A:   cfg_r.a  <= cfg_wdata[A_W-1:0];
        REG_B:   cfg_r.b  <= cfg_wdata[B_W-1:0];
        default: cfg_r    <= cfg_r;
      endcase
    end
  end

  rtd_front #(.SAMPLES(SAMPLES_PER_READING)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .code    (in_adc_code),
    .full    (in_full),
    .mq_valid(mq_valid),
    .mq_mean (mq_mean),
    .mq_pop  (mq_pop)
  );

  rtd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .mq_valid (mq_valid),
    .mq_mean  (mq_mean),
    .mq_pop   (mq_pop),
    .out_pop  (out_pop && out_valid),
    .out_valid(out_valid),
    .out_mean (out_mean_code),
    .out_res  (out_resistance_milliohm),
    .out_temp (out_temperature_centi_c),
    .out_flag (out_out_of_range)
  );

  assign out_empty = !out_valid;

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_temperature_centi_c >= T_MIN && out_temperature_centi_c <= T_MAX))
    else $error("temperature outside limits");

  a_flag_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_out_of_range) |->
      (out_temperature_centi_c == T_MAX || out_temperature_centi_c == T_MIN))
    else $error("flagged result not saturated");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_resistance_milliohm <= 18'd250000))
    else $error("resistance above full scale");

endmodule
`default_nettype wire
